/* rtl/core/ftrl_pkg.sv */
`default_nettype none
package ftrl_pkg;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_MUL,
		ST_PACC,
		ST_GRAD,
		ST_GSQ,
		ST_G2,
		ST_SQ_OLD,
		ST_SQ_NEW,
		ST_SIG_DIV,
		ST_ZMUL,
		ST_Z,
		ST_BDIV,
		ST_WDIV,
		ST_WB,
		ST_OUT
	} state_t;

	// Commands
	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L2    = 2'd3;

	// Field and datapath widths
	localparam int IDX_PORT_W = 12;
	localparam int DIV_W      = 64;
	localparam int CNT_W      = 7;

	// Saturate a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/ftrl_proximal_weight_update.sv */
// Predict item: 12 index reduction steps, one table read, one multiply, one
// accumulate and one output load.
// Update item: most of the work is in the shared one-bit-per-cycle square root and the
// shared 64-step restoring divider (the beta and weight divisions are skipped when |z|
// is within L1, the weight division on a zero denominator). One item in flight; the next
// is taken while a finished result waits. Reset: a clearing pass zeroes every entry.
`default_nettype none
module ftrl_proximal_weight_update #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int FRACTION_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [ftrl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [31:0]                        cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                command,
	input  wire  [ftrl_pkg::IDX_PORT_W-1:0]    feature_index,
	input  wire  signed [31:0]                 feature_value,
	input  wire  signed [31:0]                 gradient_scale,
	input  wire                                last_feature,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [31:0]                 partial_sum,
	output logic signed [31:0]                 weight_now,
	output logic                               last_out
);

	localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RED_W  = (IW > ftrl_pkg::IDX_PORT_W) ? IW : ftrl_pkg::IDX_PORT_W;
	localparam int SQ_IN  = 32 + FRACTION_BITS;
	localparam int SQ_W   = SQ_IN + (SQ_IN % 2);
	localparam int RW     = SQ_W / 2;
	localparam int DW     = ftrl_pkg::DIV_W;
	localparam int CW     = ftrl_pkg::CNT_W;
	localparam logic [31:0] ALPHA_RST =
		32'(((64'd5 << FRACTION_BITS) + 64'd500) / 64'd1000);
	localparam logic [31:0] BETA_RST =
		32'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

	ftrl_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// Configuration registers
	logic [31:0] alpha_q, beta_q, l1_q, l2_q;
	logic [31:0] alpha_eff;

	// Item registers
	logic             cmd_q, last_q;
	logic [RED_W-1:0] red_q;
	logic signed [31:0] x_q, s_q;

	// Table
	logic [95:0] mem [TABLE_ENTRIES];
	logic [95:0] rd_q;
	logic [IW-1:0] clr_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [95:0]   wdata;
	logic signed [31:0] w_rd, z_rd;
	logic [31:0] g2_rd;

	// Datapath registers
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [31:0] grad_q, psum_q, z_q, res_psum_q, res_w_q;
	logic [31:0] g2new_q, absz_q;
	logic [30:0] sigma_q;
	logic [RW-1:0] sqold_q, sqnew_q;
	logic [DW:0] mag_q;
	logic res_last_q;

	// Square root unit
	logic [SQ_W-1:0] sq_val_q;
	logic [RW+1:0]   sq_rem_q, sq_rem_sh, sq_trial, sq_rem_nxt;
	logic [RW-1:0]   sq_root_q, sq_root_nxt;
	logic            sq_ge;

	// Divider unit
	logic [DW-1:0] dv_num_q, dv_den_q, dv_quo_q, dv_quo_nxt;
	logic [DW:0]   dv_rem_q, dv_rem_sh, dv_rem_nxt;
	logic          dv_ge;

	// Combinational helpers
	logic               red_ge;
	logic [63:0]        red_sub;
	logic signed [31:0] psum_new, z_new, w_new;
	logic [31:0]        absz_new;
	logic               z_in_l1;
	logic [DW-1:0]      denom;
	logic [63:0]        g2_sum;

	logic               out_valid_q;
	logic signed [31:0] psum_out_q, w_out_q;
	logic               last_out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ftrl_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign partial_sum = psum_out_q;
	assign weight_now  = w_out_q;
	assign last_out    = last_out_q;

	assign alpha_eff = (alpha_q == 32'd0) ? 32'd1 : alpha_q;
	assign w_rd  = rd_q[95:64];
	assign z_rd  = rd_q[63:32];
	assign g2_rd = rd_q[31:0];

	// Index reduction step
	assign red_sub = 64'(TABLE_ENTRIES) << cnt_q;
	assign red_ge  = 64'(red_q) >= red_sub;

	// Shared multiplier
	always_comb begin
		case (state_q)
			ftrl_pkg::ST_GSQ: begin
				mul_a = grad_q;
				mul_b = grad_q;
			end
			ftrl_pkg::ST_ZMUL: begin
				mul_a = $signed({1'b0, sigma_q});
				mul_b = w_rd;
			end
			default: begin
				mul_a = (cmd_q == ftrl_pkg::CMD_UPDATE) ? s_q : w_rd;
				mul_b = x_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Square root step: one result bit per cycle
	assign sq_rem_sh   = {sq_rem_q[RW-1:0], sq_val_q[SQ_W-1 -: 2]};
	assign sq_trial    = {sq_root_q, 2'b01};
	assign sq_ge       = sq_rem_sh >= sq_trial;
	assign sq_rem_nxt  = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
	assign sq_root_nxt = {sq_root_q[RW-2:0], sq_ge};

	// Divider step: one quotient bit per cycle
	assign dv_rem_sh  = {dv_rem_q[DW-1:0], dv_num_q[DW-1]};
	assign dv_ge      = dv_rem_sh >= {1'b0, dv_den_q};
	assign dv_rem_nxt = dv_ge ? (dv_rem_sh - {1'b0, dv_den_q}) : dv_rem_sh;
	assign dv_quo_nxt = {dv_quo_q[DW-2:0], dv_ge};

	// Combinational arithmetic for the accumulate, G2, Z and BDIV states
	assign psum_new = ftrl_pkg::sat32(66'(psum_q) + 66'(prod_q >>> FRACTION_BITS));
	assign g2_sum   = 64'(g2_rd) + (64'(prod_q) >> FRACTION_BITS);
	assign z_new    = ftrl_pkg::sat32(66'(z_rd) + 66'(grad_q)
		- 66'(prod_q >>> FRACTION_BITS));
	assign absz_new = z_new[31] ? (~z_new + 32'd1) : z_new;
	assign z_in_l1  = absz_new <= l1_q;
	assign denom    = DW'(l2_q) + dv_quo_nxt;

	// Weight from magnitude and sign of z
	always_comb begin
		if (z_q > 32'sd0) begin
			if (mag_q >= (DW+1)'(33'h080000000)) begin
				w_new = 32'sh80000000;
			end else begin
				w_new = -$signed(mag_q[31:0]);
			end
		end else begin
			if (mag_q > (DW+1)'(33'h07FFFFFFF)) begin
				w_new = 32'sh7FFFFFFF;
			end else begin
				w_new = $signed(mag_q[31:0]);
			end
		end
	end

	// Next state and step counter
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ftrl_pkg::ST_CLEAR: begin
				if (clr_q == IW'(TABLE_ENTRIES - 1)) state_d = ftrl_pkg::ST_IDLE;
			end
			ftrl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ftrl_pkg::ST_REDUCE;
					cnt_d   = CW'(ftrl_pkg::IDX_PORT_W - 1);
				end
			end
			ftrl_pkg::ST_REDUCE: begin
				if (cnt_q == '0) state_d = ftrl_pkg::ST_READ;
				else cnt_d = cnt_q - 1'b1;
			end
			ftrl_pkg::ST_READ: state_d = ftrl_pkg::ST_MUL;
			ftrl_pkg::ST_MUL: begin
				state_d = (cmd_q == ftrl_pkg::CMD_UPDATE) ? ftrl_pkg::ST_GRAD
					: ftrl_pkg::ST_PACC;
			end
			ftrl_pkg::ST_PACC: state_d = ftrl_pkg::ST_OUT;
			ftrl_pkg::ST_GRAD: state_d = ftrl_pkg::ST_GSQ;
			ftrl_pkg::ST_GSQ:  state_d = ftrl_pkg::ST_G2;
			ftrl_pkg::ST_G2: begin
				state_d = ftrl_pkg::ST_SQ_OLD;
				cnt_d   = CW'(RW - 1);
			end
			ftrl_pkg::ST_SQ_OLD: begin
				if (cnt_q == '0) begin
					state_d = ftrl_pkg::ST_SQ_NEW;
					cnt_d   = CW'(RW - 1);
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ftrl_pkg::ST_SQ_NEW: begin
				if (cnt_q == '0) begin
					state_d = ftrl_pkg::ST_SIG_DIV;
					cnt_d   = CW'(DW - 1);
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ftrl_pkg::ST_SIG_DIV: begin
				if (cnt_q == '0) state_d = ftrl_pkg::ST_ZMUL;
				else cnt_d = cnt_q - 1'b1;
			end
			ftrl_pkg::ST_ZMUL: state_d = ftrl_pkg::ST_Z;
			ftrl_pkg::ST_Z: begin
				if (z_in_l1) begin
					state_d = ftrl_pkg::ST_WB;
				end else begin
					state_d = ftrl_pkg::ST_BDIV;
					cnt_d   = CW'(DW - 1);
				end
			end
			ftrl_pkg::ST_BDIV: begin
				if (cnt_q == '0) begin
					if (denom == '0) begin
						state_d = ftrl_pkg::ST_WB;
					end else begin
						state_d = ftrl_pkg::ST_WDIV;
						cnt_d   = CW'(DW - 1);
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ftrl_pkg::ST_WDIV: begin
				if (cnt_q == '0) state_d = ftrl_pkg::ST_WB;
				else cnt_d = cnt_q - 1'b1;
			end
			ftrl_pkg::ST_WB: state_d = ftrl_pkg::ST_OUT;
			ftrl_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ftrl_pkg::ST_IDLE;
			end
			default: state_d = ftrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftrl_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			l1_q    <= '0;
			l2_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ftrl_pkg::CFG_ALPHA: alpha_q <= cfg_data;
				ftrl_pkg::CFG_BETA:  beta_q  <= cfg_data;
				ftrl_pkg::CFG_L1:    l1_q    <= cfg_data;
				ftrl_pkg::CFG_L2:    l2_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clear counter, running sum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			psum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ftrl_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ftrl_pkg::ST_PACC) begin
				psum_q <= last_q ? 32'sd0 : psum_new;
			end else if (state_q == ftrl_pkg::ST_WB && last_q) begin
				psum_q <= '0;
			end
			if (state_q == ftrl_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (state_q == ftrl_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			psum_out_q <= res_psum_q;
			w_out_q    <= res_w_q;
			last_out_q <= res_last_q;
		end
	end

	// Table write port: clearing pass or write-back
	assign we    = (state_q == ftrl_pkg::ST_CLEAR) || (state_q == ftrl_pkg::ST_WB);
	assign waddr = (state_q == ftrl_pkg::ST_CLEAR) ? clr_q : red_q[IW-1:0];
	assign wdata = (state_q == ftrl_pkg::ST_CLEAR) ? 96'd0 : {w_new, z_q, g2new_q};

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read of the current entry
	always_ff @(posedge clk) begin
		rd_q <= mem[red_q[IW-1:0]];
	end

	// Datapath sequence
	always_ff @(posedge clk) begin
		case (state_q)
			ftrl_pkg::ST_IDLE: begin
				cmd_q  <= command;
				red_q  <= RED_W'(feature_index);
				x_q    <= feature_value;
				s_q    <= gradient_scale;
				last_q <= last_feature;
			end
			ftrl_pkg::ST_REDUCE: begin
				if (red_ge) red_q <= red_q - RED_W'(red_sub);
			end
			ftrl_pkg::ST_MUL: prod_q <= mul_p;
			ftrl_pkg::ST_PACC: begin
				res_psum_q <= psum_new;
				res_w_q    <= w_rd;
				res_last_q <= last_q;
			end
			ftrl_pkg::ST_GRAD: grad_q <= ftrl_pkg::sat32(66'(prod_q >>> FRACTION_BITS));
			ftrl_pkg::ST_GSQ:  prod_q <= mul_p;
			ftrl_pkg::ST_G2: begin
				g2new_q   <= (g2_sum > 64'h0FFFFFFFF) ? 32'hFFFFFFFF : g2_sum[31:0];
				sq_val_q  <= SQ_W'({g2_rd, {FRACTION_BITS{1'b0}}});
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			ftrl_pkg::ST_SQ_OLD: begin
				sq_val_q  <= sq_val_q << 2;
				sq_rem_q  <= sq_rem_nxt;
				sq_root_q <= sq_root_nxt;
				if (cnt_q == '0) begin
					sqold_q   <= sq_root_nxt;
					sq_val_q  <= SQ_W'({g2new_q, {FRACTION_BITS{1'b0}}});
					sq_rem_q  <= '0;
					sq_root_q <= '0;
				end
			end
			ftrl_pkg::ST_SQ_NEW: begin
				sq_val_q  <= sq_val_q << 2;
				sq_rem_q  <= sq_rem_nxt;
				sq_root_q <= sq_root_nxt;
				if (cnt_q == '0) begin
					sqnew_q  <= sq_root_nxt;
					dv_num_q <= DW'(sq_root_nxt - sqold_q) << FRACTION_BITS;
					dv_den_q <= DW'(alpha_eff);
					dv_rem_q <= '0;
					dv_quo_q <= '0;
				end
			end
			ftrl_pkg::ST_SIG_DIV: begin
				dv_num_q <= dv_num_q << 1;
				dv_rem_q <= dv_rem_nxt;
				dv_quo_q <= dv_quo_nxt;
				if (cnt_q == '0) begin
					sigma_q <= (dv_quo_nxt > DW'(32'h7FFFFFFF)) ? 31'h7FFFFFFF
						: dv_quo_nxt[30:0];
				end
			end
			ftrl_pkg::ST_ZMUL: prod_q <= mul_p;
			ftrl_pkg::ST_Z: begin
				z_q      <= z_new;
				absz_q   <= absz_new;
				mag_q    <= '0;
				dv_num_q <= (DW'(beta_q) + DW'(sqnew_q)) << FRACTION_BITS;
				dv_den_q <= DW'(alpha_eff);
				dv_rem_q <= '0;
				dv_quo_q <= '0;
			end
			ftrl_pkg::ST_BDIV: begin
				dv_num_q <= dv_num_q << 1;
				dv_rem_q <= dv_rem_nxt;
				dv_quo_q <= dv_quo_nxt;
				if (cnt_q == '0) begin
					mag_q    <= (DW+1)'(1) << 32;
					dv_num_q <= DW'(absz_q - l1_q) << FRACTION_BITS;
					dv_den_q <= denom;
					dv_rem_q <= '0;
					dv_quo_q <= '0;
				end
			end
			ftrl_pkg::ST_WDIV: begin
				dv_num_q <= dv_num_q << 1;
				dv_rem_q <= dv_rem_nxt;
				dv_quo_q <= dv_quo_nxt;
				if (cnt_q == '0) mag_q <= (DW+1)'(dv_quo_nxt);
			end
			ftrl_pkg::ST_WB: begin
				res_psum_q <= '0;
				res_w_q    <= w_new;
				res_last_q <= last_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/ftrl_chk.sv */
`default_nettype none
module ftrl_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire               out_valid,
	input wire               out_ready,
	input wire signed [31:0] partial_sum,
	input wire signed [31:0] weight_now,
	input wire               last_out
);

	logic [1:0] pend_q;
	logic       in_xact, out_xact;

	assign in_xact  = in_valid && in_ready;
	assign out_xact = out_valid && out_ready;

	// Count transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xact} - {1'b0, out_xact};
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many transactions in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !in_ready)
		else $error("second transaction taken while one is in work");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(partial_sum)
			&& $stable(weight_now) && $stable(last_out))
		else $error("stalled result changed");

endmodule

bind ftrl_proximal_weight_update ftrl_chk u_ftrl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.partial_sum (partial_sum),
	.weight_now  (weight_now),
	.last_out    (last_out)
);
`default_nettype wire
